/* sv/wgp_pkg.sv */
package wgp_pkg;

  localparam int SOUND_DEPTH  = 65536;
  localparam int WINDOW_DEPTH = 4096;
  localparam int SAMPLE_BITS  = 16;

  localparam int SND_AW = $clog2(SOUND_DEPTH);
  localparam int WIN_AW = $clog2(WINDOW_DEPTH);

  localparam int DIV_NW = 41;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_TRIG,
    KIND_SND_WR,
    KIND_WIN_WR
  } kind_t;

  typedef enum logic [2:0] {
    CFG_SOUND_FRAMES,
    CFG_WINDOW_FRAMES,
    CFG_SOUND_INTERP,
    CFG_WINDOW_INTERP,
    CFG_REVERSE,
    CFG_SOUND_RATE,
    CFG_OUTPUT_RATE
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

/* sv/wgp_div.sv */
module wgp_div
  import wgp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic              done;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;

  assign trial = {rem, quo[DIV_NW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

/* sv/wgp_tables.sv */
module wgp_tables
  import wgp_pkg::*;
(
  input  logic                          clk,
  input  logic                          snd_we,
  input  logic                          win_we,
  input  logic [SND_AW-1:0]             snd_waddr,
  input  logic [WIN_AW-1:0]             win_waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic [SND_AW-1:0]             snd_raddr,
  input  logic [WIN_AW-1:0]             win_raddr,
  output logic signed [SAMPLE_BITS-1:0] snd_rdata,
  output logic signed [SAMPLE_BITS-1:0] win_rdata
);

  logic signed [SAMPLE_BITS-1:0] snd_mem [SOUND_DEPTH];
  logic signed [SAMPLE_BITS-1:0] win_mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (snd_we) begin
      snd_mem[snd_waddr] <= wdata;
    end
    snd_rdata <= snd_mem[snd_raddr];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= wdata;
    end
    win_rdata <= win_mem[win_raddr];
  end

endmodule

/* sv/windowed_grain_player_top.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | kind start_ms length_ms pitch table_address
//         |           |                    | table_data
// out     | output    | out_valid/out_ready| sample_out overflow grain_active
// cfg     | input     | cfg_we             | cfg_index cfg_data
//
// Table writes, triggers and idle ticks go straight from S_IDLE to S_DONE.
// A playing tick makes two remainder passes on the shared divider, then two table
// reads and three passes on the shared multiplier.
// A tick that ends the grain skips the reads.
// A grain start tick makes four divider passes on the same unit (and one more multiplier pass when reversed).
// Reset is synchronous; the tables keep their contents and need no clearing pass.
// A stalled result holds in the output register while the next item is accepted.
module windowed_grain_player_top
  import wgp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [19:0]                   start_ms,
  input  logic [15:0]                   length_ms,
  input  logic [15:0]                   pitch,
  input  logic [15:0]                   table_address,
  input  logic signed [SAMPLE_BITS-1:0] table_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          overflow,
  output logic                          grain_active,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [16:0]                   cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_STEP_MUL, S_STEP_DIV, S_STEP_MOD, S_WIN_MUL, S_WIN_DIV,
    S_PH_MUL, S_PH_MUL2, S_PH_MOD, S_ADV_ST, S_ADV_PH, S_ADV_SUM,
    S_RD0, S_RD1, S_RD2, S_IS_MUL, S_IW_MUL, S_PROD, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {ST_IDLE, ST_PLAY, ST_ARMED} stage_t;

  localparam logic [31:0] MAXW = 32'((WINDOW_DEPTH + 1) * 65536);

  state_t state;
  stage_t stage;

  logic [16:0] sound_frames;
  logic [12:0] window_frames;
  logic        sound_interp;
  logic        window_interp;
  logic        reverse;
  logic [15:0] sound_rate;
  logic [15:0] output_rate;

  logic [16:0] sf;
  logic [12:0] wf;
  logic [15:0] srate;
  logic [15:0] orate;
  logic [15:0] len_e;
  logic [32:0] slen;

  logic [19:0] start_r;
  logic [15:0] length_r;
  logic [15:0] pitch_r;
  logic        rev_r;

  logic [31:0] sound_phase;
  logic [31:0] window_phase;
  logic [31:0] sound_step;
  logic [31:0] window_step;
  logic [DIV_NW-1:0] acc;
  logic [31:0] st_r;
  logic [31:0] p_r;

  logic signed [SAMPLE_BITS-1:0] snd_a, snd_b, win_a, win_b;
  logic signed [16:0] s_val;
  logic signed [16:0] w_val;

  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                          res_ovf;

  logic               mul_en;
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p;
  logic signed [52:0] rnd16;
  logic signed [52:0] rnd15;

  logic     div_go;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [33:0] adv_sum;
  logic [31:0] ph_new;
  logic [31:0] wp_new;

  logic [12:0]       win_idx;
  logic [WIN_AW-1:0] wi0, wi1;
  logic [SND_AW-1:0] si0, si1;
  logic [SND_AW-1:0] snd_raddr;
  logic [WIN_AW-1:0] win_raddr;
  logic signed [SAMPLE_BITS-1:0] snd_rdata, win_rdata;
  logic snd_we, win_we;
  logic accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    if (sound_frames == 17'd0) begin
      sf = 17'd1;
    end else if (sound_frames > 17'(SOUND_DEPTH)) begin
      sf = 17'(SOUND_DEPTH);
    end else begin
      sf = sound_frames;
    end
    if (window_frames < 13'd2) begin
      wf = 13'd2;
    end else if (window_frames > 13'(WINDOW_DEPTH)) begin
      wf = 13'(WINDOW_DEPTH);
    end else begin
      wf = window_frames;
    end
  end

  assign srate = (sound_rate == 16'd0) ? 16'd1 : sound_rate;
  assign orate = (output_rate == 16'd0) ? 16'd1 : output_rate;
  assign len_e = (length_r == 16'd0) ? 16'd1 : length_r;
  assign slen  = {sf, 16'b0};

  // shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_STEP_MUL: begin
        mul_a = 35'(pitch_r);
        mul_b = 18'(srate);
      end
      S_WIN_MUL: begin
        mul_a = 35'(len_e);
        mul_b = 18'(orate);
      end
      S_PH_MUL: begin
        mul_a = rev_r ? 35'(len_e) : 35'(start_r);
        mul_b = rev_r ? 18'(pitch_r) : 18'(srate);
      end
      S_PH_MUL2: begin
        mul_a = 35'({start_r, 12'b0}) + 35'(mul_p[31:0]);
        mul_b = 18'(srate);
      end
      S_IS_MUL: begin
        mul_a = 35'(17'(snd_b) - 17'(snd_a));
        mul_b = 18'(sound_phase[15:0]);
      end
      S_IW_MUL: begin
        mul_a = 35'(17'(win_b) - 17'(win_a));
        mul_b = 18'(window_phase[15:0]);
      end
      S_PROD: begin
        mul_a = 35'(s_val);
        mul_b = 18'(w_val);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= 53'(mul_a) * 53'(mul_b);
    end
  end

  assign rnd16 = (mul_p + 53'sd32768) >>> 16;
  assign rnd15 = (mul_p + 53'sd16384) >>> 15;
  assign w_val = window_interp ? 17'(win_a) + rnd16[16:0] : 17'(win_a);

  // shared divider
  always_comb begin
    div_req.start    = div_go;
    div_req.dividend = '0;
    div_req.divisor  = 32'(sf);
    case (state)
      S_STEP_DIV: begin
        div_req.dividend = DIV_NW'({mul_p[31:0], 4'b0});
        div_req.divisor  = 32'(orate);
      end
      S_STEP_MOD: div_req.dividend = DIV_NW'(acc[DIV_NW-1:16]);
      S_WIN_DIV: begin
        div_req.dividend = {wf, 28'b0};
        div_req.divisor  = mul_p[31:0];
      end
      S_PH_MOD:
        div_req.dividend = rev_r ? DIV_NW'(mul_p[48:24]) : DIV_NW'(mul_p[35:12]);
      S_ADV_ST: div_req.dividend = DIV_NW'(sound_step[31:16]);
      S_ADV_PH: div_req.dividend = DIV_NW'(sound_phase[31:16]);
      default: div_req.dividend = '0;
    endcase
  end

  wgp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // phase advance
  always_comb begin
    if (rev_r) begin
      adv_sum = 34'(p_r) + 34'(slen) - 34'(st_r);
    end else begin
      adv_sum = 34'(p_r) + 34'(st_r);
    end
    if (adv_sum >= 34'(slen)) begin
      ph_new = 32'(adv_sum - 34'(slen));
    end else begin
      ph_new = adv_sum[31:0];
    end
  end

  assign wp_new = window_phase + window_step;

  // table addresses
  assign win_idx = window_phase[28:16];
  assign wi0 = (win_idx == wf) ? '0 : win_idx[WIN_AW-1:0];
  assign wi1 = (13'(wi0) + 13'd1 == wf) ? '0 : wi0 + 1'b1;
  assign si0 = sound_phase[31:16];
  assign si1 = (17'(si0) + 17'd1 == sf) ? '0 : si0 + 1'b1;
  assign snd_raddr = (state == S_RD1) ? si1 : si0;
  assign win_raddr = (state == S_RD1) ? wi1 : wi0;

  assign snd_we = accept && (kind == KIND_SND_WR);
  assign win_we = accept && (kind == KIND_WIN_WR) && (table_address[15:WIN_AW] == '0);

  wgp_tables u_tables (
    .clk       (clk),
    .snd_we    (snd_we),
    .win_we    (win_we),
    .snd_waddr (table_address[SND_AW-1:0]),
    .win_waddr (table_address[WIN_AW-1:0]),
    .wdata     (table_data),
    .snd_raddr (snd_raddr),
    .win_raddr (win_raddr),
    .snd_rdata (snd_rdata),
    .win_rdata (win_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stage         <= ST_IDLE;
      rev_r         <= 1'b0;
      sound_phase   <= '0;
      window_phase  <= MAXW;
      sound_step    <= '0;
      window_step   <= '0;
      div_go        <= 1'b0;
      out_valid     <= 1'b0;
      sound_frames  <= 17'd65536;
      window_frames <= 13'd4096;
      sound_interp  <= 1'b1;
      window_interp <= 1'b1;
      reverse       <= 1'b0;
      sound_rate    <= 16'd11290;
      output_rate   <= 16'd11290;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOUND_FRAMES:  sound_frames  <= cfg_data;
          CFG_WINDOW_FRAMES: window_frames <= cfg_data[12:0];
          CFG_SOUND_INTERP:  sound_interp  <= cfg_data[0];
          CFG_WINDOW_INTERP: window_interp <= cfg_data[0];
          CFG_REVERSE:       reverse       <= cfg_data[0];
          CFG_SOUND_RATE:    sound_rate    <= cfg_data[15:0];
          CFG_OUTPUT_RATE:   output_rate   <= cfg_data[15:0];
          default: ;
        endcase
      end
      div_go <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            start_r    <= start_ms;
            length_r   <= length_ms;
            pitch_r    <= pitch;
            res_ovf    <= 1'b0;
            res_sample <= '0;
            state      <= S_DONE;
            case (kind)
              KIND_TRIG: begin
                if (stage == ST_IDLE) begin
                  stage <= ST_ARMED;
                end else begin
                  res_ovf <= 1'b1;
                end
              end
              KIND_TICK: begin
                if (stage == ST_ARMED) begin
                  rev_r <= reverse;
                  state <= S_STEP_MUL;
                end else if (stage == ST_PLAY) begin
                  div_go <= 1'b1;
                  state  <= S_ADV_ST;
                end
              end
              default: ;
            endcase
          end
        end
        S_STEP_MUL: begin
          div_go <= 1'b1;
          state  <= S_STEP_DIV;
        end
        S_STEP_DIV: begin
          if (div_rsp.done) begin
            acc    <= div_rsp.quot;
            div_go <= 1'b1;
            state  <= S_STEP_MOD;
          end
        end
        S_STEP_MOD: begin
          if (div_rsp.done) begin
            sound_step <= {div_rsp.rem[15:0], acc[15:0]};
            state      <= S_WIN_MUL;
          end
        end
        S_WIN_MUL: begin
          div_go <= 1'b1;
          state  <= S_WIN_DIV;
        end
        S_WIN_DIV: begin
          if (div_rsp.done) begin
            window_step <= (div_rsp.quot > DIV_NW'(MAXW)) ? MAXW : div_rsp.quot[31:0];
            state       <= S_PH_MUL;
          end
        end
        S_PH_MUL: begin
          if (rev_r) begin
            state <= S_PH_MUL2;
          end else begin
            div_go <= 1'b1;
            state  <= S_PH_MOD;
          end
        end
        S_PH_MUL2: begin
          div_go <= 1'b1;
          state  <= S_PH_MOD;
        end
        S_PH_MOD: begin
          if (div_rsp.done) begin
            sound_phase  <= rev_r ? {div_rsp.rem[15:0], mul_p[23:8]}
                                  : {div_rsp.rem[15:0], mul_p[11:0], 4'b0};
            window_phase <= '0;
            stage        <= ST_PLAY;
            state        <= S_RD0;
          end
        end
        S_ADV_ST: begin
          if (div_rsp.done) begin
            st_r   <= {div_rsp.rem[15:0], sound_step[15:0]};
            div_go <= 1'b1;
            state  <= S_ADV_PH;
          end
        end
        S_ADV_PH: begin
          if (div_rsp.done) begin
            p_r   <= {div_rsp.rem[15:0], sound_phase[15:0]};
            state <= S_ADV_SUM;
          end
        end
        S_ADV_SUM: begin
          sound_phase  <= ph_new;
          window_phase <= wp_new;
          if (wp_new > 32'({wf, 16'b0})) begin
            stage <= ST_IDLE;
            state <= S_DONE;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          snd_a <= snd_rdata;
          win_a <= win_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          snd_b <= snd_rdata;
          win_b <= win_rdata;
          state <= S_IS_MUL;
        end
        S_IS_MUL: state <= S_IW_MUL;
        S_IW_MUL: begin
          s_val <= sound_interp ? 17'(snd_a) + rnd16[16:0] : 17'(snd_a);
          state <= S_PROD;
        end
        S_PROD: state <= S_FIN;
        S_FIN: begin
          if (rnd15 > 53'sd32767) begin
            res_sample <= 16'sh7fff;
          end else if (rnd15 < -53'sd32768) begin
            res_sample <= 16'sh8000;
          end else begin
            res_sample <= rnd15[15:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            sample_out   <= res_sample;
            overflow     <= res_ovf;
            grain_active <= (stage != ST_IDLE);
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted twice without finishing");

  a_ovf_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> grain_active)
    else $error("overflow reported without an active grain");

  a_ovf_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> sample_out == '0)
    else $error("overflow beat carries a sample");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_go |-> (state == S_STEP_DIV || state == S_STEP_MOD || state == S_WIN_DIV ||
                state == S_PH_MOD || state == S_ADV_ST || state == S_ADV_PH))
    else $error("divider started outside a divide step");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import wgp_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  CYCLE_LIMIT = 5000000;
  localparam int  DRAIN_WAIT  = 250;
  localparam int  SND_LOADED  = 64;
  localparam int  WIN_LOADED  = 64;

  typedef struct {
    kind_t       kind;
    logic [19:0] start;
    logic [15:0] len;
    logic [15:0] pitch;
    logic [15:0] addr;
    logic [15:0] data;
  } grain_cmd_t;

  typedef struct {
    logic [15:0] smp;
    logic        ovf;
    logic        act;
  } grain_out_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    kind = '0;
  logic [19:0]                   start_ms = '0;
  logic [15:0]                   length_ms = '0;
  logic [15:0]                   pitch = '0;
  logic [15:0]                   table_address = '0;
  logic signed [SAMPLE_BITS-1:0] table_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          overflow;
  logic                          grain_active;
  logic                          cfg_we = 1'b0;
  logic [2:0]                    cfg_index = '0;
  logic [16:0]                   cfg_data = '0;

  windowed_grain_player_top u_dut (.*);

  always #HALF_PERIOD clk = ~clk;

  // grain predictor state
  logic signed [15:0] snd_tab [SOUND_DEPTH];
  logic signed [15:0] win_tab [WINDOW_DEPTH];
  longint unsigned    snd_ph, win_ph, snd_stp, win_stp;
  logic [1:0]         stage;
  bit                 rev_lat;
  logic [16:0]        r_sf;
  logic [12:0]        r_wf;
  bit                 r_si, r_wi, r_rev;
  logic [15:0]        r_srate, r_orate;

  localparam logic [1:0] STG_IDLE = 2'd0, STG_PLAY = 2'd1, STG_ARMED = 2'd2;

  grain_out_t expected_q[$];
  int         errors = 0;
  int         sent = 0;
  bit         calm = 0;
  longint     cycles = 0;

  function automatic longint lerp_read(bit win, longint unsigned frames,
                                       longint unsigned ph, bit interp);
    longint unsigned i0, i1;
    longint a, b, fr;
    i0 = (ph >> 16) % frames;
    i1 = (i0 + 1) % frames;
    a  = win ? longint'(win_tab[i0]) : longint'(snd_tab[i0]);
    b  = win ? longint'(win_tab[i1]) : longint'(snd_tab[i1]);
    fr = longint'(ph & 64'hFFFF);
    if (!interp) return a;
    return a + (((b - a) * fr + 32768) >>> 16);
  endfunction

  function automatic grain_out_t grain_predict(grain_cmd_t c);
    grain_out_t      r;
    longint unsigned sf, wf, slen, sr, orr, ln, pt, st, p, maxw;
    longint          w, s, y;
    bit              live;
    r.smp = '0;
    r.ovf = 1'b0;
    y = 0;
    case (c.kind)
      KIND_SND_WR: snd_tab[c.addr] = c.data;
      KIND_WIN_WR: if (c.addr < WINDOW_DEPTH) win_tab[c.addr[WIN_AW-1:0]] = c.data;
      KIND_TRIG: begin
        if (stage == STG_IDLE) stage = STG_ARMED;
        else r.ovf = 1'b1;
      end
      default: begin
        if (stage != STG_IDLE) begin
          sf   = (r_sf < 1) ? 1 : (r_sf > SOUND_DEPTH) ? SOUND_DEPTH : r_sf;
          wf   = (r_wf < 2) ? 2 : (r_wf > WINDOW_DEPTH) ? WINDOW_DEPTH : r_wf;
          slen = sf << 16;
          sr   = (r_srate == 0) ? 1 : r_srate;
          orr  = (r_orate == 0) ? 1 : r_orate;
          live = 1;
          if (stage == STG_ARMED) begin
            maxw    = longint'(WINDOW_DEPTH + 1) << 16;
            ln      = (c.len == 0) ? 1 : c.len;
            pt      = c.pitch;
            rev_lat = r_rev;
            snd_stp = ((pt * sr) << 4) / orr % slen;
            win_stp = (wf << 28) / (ln * orr);
            if (win_stp > maxw) win_stp = maxw;
            if (!rev_lat) snd_ph = ((longint'(c.start) * sr) << 4) % slen;
            else snd_ph = ((((longint'(c.start)) << 12) + ln * pt) * sr >> 8) % slen;
            win_ph = 0;
            stage  = STG_PLAY;
          end else begin
            st = snd_stp % slen;
            p  = snd_ph % slen;
            snd_ph = rev_lat ? (p + slen - st) % slen : (p + st) % slen;
            win_ph += win_stp;
            if (win_ph > (wf << 16)) begin
              stage = STG_IDLE;
              live  = 0;
            end
          end
          if (live) begin
            w = lerp_read(1, wf, win_ph, r_wi);
            s = lerp_read(0, sf, snd_ph % slen, r_si);
            y = (s * w + 16384) >>> 15;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
          end
        end
      end
    endcase
    r.smp = y[15:0];
    r.act = (stage != STG_IDLE);
    return r;
  endfunction

  task automatic send(kind_t k, logic [19:0] st, logic [15:0] ln, logic [15:0] pt,
                      logic [15:0] ad, logic [15:0] dt);
    grain_cmd_t c;
    c = '{k, st, ln, pt, ad, dt};
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    expected_q.push_back(grain_predict(c));
    sent++;
    in_valid      <= 1'b1;
    kind          <= k;
    start_ms      <= st;
    length_ms     <= ln;
    pitch         <= pt;
    table_address <= ad;
    table_data    <= dt;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic tick(logic [19:0] st, logic [15:0] ln, logic [15:0] pt);
    send(KIND_TICK, st, ln, pt, 16'($urandom), 16'($urandom));
  endtask

  task automatic trig();
    send(KIND_TRIG, 20'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_cfg(logic [16:0] sf, logic [12:0] wf, bit si, bit wi, bit rv,
                         logic [15:0] sr, logic [15:0] orr);
    logic [16:0] v;
    for (int i = 0; i < 7; i++) begin
      case (cfg_idx_t'(i))
        CFG_SOUND_FRAMES:  begin v = sf;       r_sf = sf; end
        CFG_WINDOW_FRAMES: begin v = 17'(wf);  r_wf = wf; end
        CFG_SOUND_INTERP:  begin v = 17'(si);  r_si = si; end
        CFG_WINDOW_INTERP: begin v = 17'(wi);  r_wi = wi; end
        CFG_REVERSE:       begin v = 17'(rv);  r_rev = rv; end
        CFG_SOUND_RATE:    begin v = 17'(sr);  r_srate = sr; end
        default:           begin v = 17'(orr); r_orate = orr; end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // play one grain long enough to pass the end of its window
  task automatic play_grain(logic [19:0] st, logic [15:0] ln, logic [15:0] pt);
    longint unsigned orr, n;
    orr = (r_orate == 0) ? 1 : r_orate;
    n   = ((ln == 0 ? 1 : ln) * orr) / 4096 + 3;
    if (n > 60) n = 60;
    trig();
    tick(st, ln, pt);
    for (int i = 0; i < n; i++) begin
      if (stage != STG_IDLE && $urandom_range(0, 15) == 0) trig();
      if ($urandom_range(0, 20) == 0)
        send(KIND_SND_WR, 20'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom_range(0, SND_LOADED - 1)), 16'($urandom));
      tick(20'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [15:0] fit_len(logic [15:0] orr);
    longint unsigned o, m;
    o = (orr == 0) ? 1 : orr;
    m = 120000 / o;
    if (m < 1) m = 1;
    if (m > 65535) m = 65535;
    return 16'($urandom_range(1, int'(m)));
  endfunction

  task automatic test_tables_and_reset_grain();
    send(KIND_SND_WR, 20'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
    send(KIND_SND_WR, 20'd0, 16'd0, 16'd0, 16'd1, 16'h8000);
    for (int i = 2; i < SND_LOADED; i++)
      send(KIND_SND_WR, 20'($urandom), 16'($urandom), 16'($urandom), 16'(i), 16'($urandom));
    send(KIND_SND_WR, 20'd0, 16'd0, 16'd0, 16'hFFFF, 16'h5A5A);
    send(KIND_WIN_WR, 20'd0, 16'd0, 16'd0, 16'hFFFF, 16'h1234);
    send(KIND_WIN_WR, 20'd0, 16'd0, 16'd0, 16'h1000, 16'h4321);
    for (int i = 0; i < WIN_LOADED; i++)
      send(KIND_WIN_WR, 20'd0, 16'd0, 16'd0, 16'(i),
           (i < 2) ? 16'h7FFF : (i == 2) ? 16'h8000 : 16'($urandom));
    tick(20'd0, 16'd16, 16'd0);
    trig();
    trig();
    tick(20'd0, 16'd0, 16'd0);
    for (int i = 0; i < 5; i++) tick(20'd0, 16'd0, 16'd0);
    drain();
    set_cfg(17'd65536, 13'(WIN_LOADED), 1'b1, 1'b1, 1'b0, 16'd11290, 16'd11290);
    trig();
    tick(20'd0, 16'd16, 16'd0);
    for (int i = 0; i < 50; i++) tick(20'hFFFFF, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_config_extremes();
    set_cfg(17'd1, 13'd2, 1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
    play_grain(20'hFFFFF, 16'd1, 16'hFFFF);
    drain();
    set_cfg(17'd0, 13'd0, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0);
    play_grain(20'hFFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    set_cfg(17'h1FFFF, 13'h1FFF, 1'b1, 1'b0, 1'b1, 16'h2C1A, 16'h0001);
    play_grain(20'd0, 16'd4, 16'd0);
    drain();
    set_cfg(17'h10000, 13'(WIN_LOADED), 1'b0, 1'b1, 1'b0, 16'h0001, 16'h0001);
    play_grain(20'd0, 16'hFFFF, 16'd0);
    drain();
    set_cfg(17'(SND_LOADED), 13'(WIN_LOADED), 1'b1, 1'b1, 1'b1, 16'h1234, 16'h0800);
    play_grain(20'h55555, 16'd8, 16'h1000);
    drain();
  endtask

  task automatic random_phase(int items);
    int          n0;
    logic [15:0] orr;
    orr = 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 1)) orr = 16'($urandom_range(2000, 20000));
    set_cfg(17'($urandom_range(1, SND_LOADED)), 13'($urandom_range(2, WIN_LOADED)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
            16'($urandom_range(1, 65535)), orr);
    n0 = sent;
    while (sent - n0 < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          play_grain(20'($urandom), fit_len(r_orate), 16'($urandom));
        end
        7: begin
          send(KIND_SND_WR, 20'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(0, SND_LOADED - 1)), 16'($urandom));
        end
        8: begin
          send(KIND_WIN_WR, 20'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(0, 8191)), 16'($urandom));
        end
        default: begin
          if ($urandom_range(0, 1)) trig();
          else tick(20'($urandom), 16'($urandom), 16'($urandom));
        end
      endcase
    end
    drain();
  endtask

  task automatic test_random_grains();
    for (int ph = 0; ph < 2; ph++) begin
      random_phase(60);
      drain();
      random_phase(60);
    end
  endtask

  task automatic test_quiet_tail();
    calm = 1;
    random_phase(60);
  endtask

  // result checker: sample at the falling edge, beat lands on the next rising edge
  always @(negedge clk) begin
    grain_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        if (errors < 10) $display("unexpected result: sample %h", sample_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (sample_out !== e.smp || overflow !== e.ovf || grain_active !== e.act) begin
          if (errors < 10)
            $display("mismatch: exp smp %h ovf %b act %b, got smp %h ovf %b act %b",
                     e.smp, e.ovf, e.act, sample_out, overflow, grain_active);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    stage   = STG_IDLE;
    rev_lat = 0;
    snd_ph  = 0;
    win_ph  = longint'(WINDOW_DEPTH + 1) << 16;
    snd_stp = 0;
    win_stp = 0;
    r_sf    = 17'd65536;
    r_wf    = 13'd4096;
    r_si    = 1;
    r_wi    = 1;
    r_rev   = 0;
    r_srate = 16'd11290;
    r_orate = 16'd11290;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tables_and_reset_grain();
    test_config_extremes();
    test_random_grains();
    test_quiet_tail();
    drain();
    if (expected_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/wgp_pkg.sv
sv/wgp_div.sv
sv/wgp_tables.sv
sv/windowed_grain_player_top.sv
dv/tb_top.sv
